// ===== src/acc4_pkg.sv =====
// ----------------------------------------------------------------------------
// acc4_pkg
// Types and constants shared by the 4-bit accumulator execute block.
// ----------------------------------------------------------------------------
package acc4_pkg;

	localparam int NIB_W  = 4;
	localparam int PC_W   = 8;
	localparam int INS_W  = 8;
	localparam int IDX_W  = 3;
	localparam int TGT_W  = 7;

	// instruction bit positions
	localparam int BRANCH_POS = 7;
	localparam int IMM_POS    = 6;
	localparam int STORE_POS  = 3;
	localparam int SIGN_POS   = 3;

	// fixed register roles
	localparam logic [IDX_W-1:0] OUT_PORT_IDX = 3'd0;
	localparam logic [IDX_W-1:0] IN_PORT_IDX  = 3'd1;

	// low two opcode bits; bit 6 picks immediate vs register operand
	typedef enum logic [1:0] {
		ALU_ADD  = 2'd0,
		ALU_NAND = 2'd1,
		ALU_XOR  = 2'd2,
		ALU_MISC = 2'd3
	} alu_op_t;

	// register write request from the execute logic
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} store_req_t;

	// architectural outcome of one instruction
	typedef struct packed {
		logic [PC_W-1:0]  pc;
		logic [NIB_W-1:0] acc;
		store_req_t       st;
	} exec_res_t;

endpackage

// ===== src/acc4_exec.sv =====
// ----------------------------------------------------------------------------
// acc4_exec
// Decode and execute of one instruction: next pc, accumulator, store request.
// ----------------------------------------------------------------------------
module acc4_exec import acc4_pkg::*; #(
	parameter int REG_COUNT = 8
) (
	input  logic [INS_W-1:0] instruction,
	input  logic [PC_W-1:0]  pc,
	input  logic [NIB_W-1:0] acc,
	input  logic [NIB_W-1:0] regs [REG_COUNT],
	output exec_res_t        res
);

	logic [IDX_W-1:0] idx;
	logic [NIB_W-1:0] rd_val;
	logic [NIB_W-1:0] opnd;
	alu_op_t          op;
	logic             use_imm;

	assign idx     = instruction[IDX_W-1:0];
	assign use_imm = instruction[IMM_POS];
	assign op      = alu_op_t'(instruction[5:4]);

	// register read, indexes past the file read as zero
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < REG_COUNT; i++) begin
			if (idx == IDX_W'(i)) begin
				rd_val = regs[i];
			end
		end
	end

	assign opnd = use_imm ? instruction[NIB_W-1:0] : rd_val;

	// alu, load/store and branch
	always_comb begin
		res.pc     = pc + PC_W'(1);
		res.acc    = acc;
		res.st.en  = 1'b0;
		res.st.idx = idx;
		if (instruction[BRANCH_POS]) begin
			if (acc[SIGN_POS]) begin
				res.pc = {1'b0, instruction[TGT_W-1:0]};
			end
		end else begin
			unique case (op)
				ALU_ADD:  res.acc = opnd + acc;
				ALU_NAND: res.acc = ~(opnd & acc);
				ALU_XOR:  res.acc = opnd ^ acc;
				ALU_MISC: begin
					// reserved code without immediate bit is a no-op
					if (use_imm) begin
						if (instruction[STORE_POS]) begin
							res.st.en = 1'b1;
						end else begin
							res.acc = rd_val;
						end
					end
				end
				default: res.acc = acc;
			endcase
		end
	end

endmodule

// ===== src/accumulator_cpu_4bit_execute_top.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_4bit_execute_top
// Executes one instruction per request on a 4-bit accumulator machine.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                    | tuser
// s_*     | in  | instruction[7:0], port_value[11:8]    | port_write[0], pc_clear[1]
// m_*     | out | fetch_address[7:0], accumulator[11:8], | -
//         |     | output_port[15:12]                    |
//
// One request per cycle unless output stalls; passes input, then output register.
// The input stage executes against pc, accumulator and register file in the
// same cycle it hands its result to the output register.
// Reset clears pc, accumulator, all registers and both valid flags.
// A stalled output holds the input stage, which then drops s_tready.
// ----------------------------------------------------------------------------
module accumulator_cpu_4bit_execute_top import acc4_pkg::*; #(
	parameter int REG_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // instruction[7:0], port_value[11:8], zero pad
	input  logic [1:0]  s_tuser,  // port_write[0], pc_clear[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // fetch_address[7:0], accumulator[11:8], output_port[15:12]
);

	logic             valid_s1;
	logic [INS_W-1:0] ins_s1;
	logic [NIB_W-1:0] pv_s1;
	logic             pw_s1;
	logic             pcc_s1;
	logic             advance;

	logic [PC_W-1:0]  pc_q;
	logic [NIB_W-1:0] acc_q;
	logic [NIB_W-1:0] reg_q [REG_COUNT];

	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	exec_res_t        res;
	logic [PC_W-1:0]  pc_nxt;
	logic [NIB_W-1:0] reg0_nxt;

	// stage moves when the output register is free or being drained
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ins_s1 <= s_tdata[7:0];
			pv_s1  <= s_tdata[11:8];
			pw_s1  <= s_tuser[0];
			pcc_s1 <= s_tuser[1];
		end
	end

	acc4_exec #(
		.REG_COUNT (REG_COUNT)
	) u_exec (
		.instruction (ins_s1),
		.pc          (pc_q),
		.acc         (acc_q),
		.regs        (reg_q),
		.res         (res)
	);

	// port inputs applied after the instruction
	assign pc_nxt   = pcc_s1 ? '0 : res.pc;
	assign reg0_nxt = (res.st.en && res.st.idx == OUT_PORT_IDX) ? acc_q : reg_q[0];

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			acc_q <= '0;
			for (int i = 0; i < REG_COUNT; i++) begin
				reg_q[i] <= '0;
			end
		end else if (advance) begin
			pc_q  <= pc_nxt;
			acc_q <= res.acc;
			for (int i = 0; i < REG_COUNT; i++) begin
				if (pw_s1 && IDX_W'(i) == IN_PORT_IDX) begin
					reg_q[i] <= pv_s1;
				end else if (res.st.en && res.st.idx == IDX_W'(i)) begin
					reg_q[i] <= acc_q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {reg0_nxt, res.acc, pc_nxt};
		end
	end

`ifndef SYNTHESIS
	// a finished stage always lands in the output register
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result not presented after advance");

	// backpressure only from a full, stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid_q && !m_tready))
		else $error("input stalled without output stall");

	// pc clear yields fetch address zero
	a_pc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pcc_s1) |=> (m_tdata[7:0] == 8'd0 && pc_q == '0))
		else $error("pc clear not applied");

	// port write lands in the input port register
	a_port_write: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pw_s1) |=> (reg_q[1] == $past(pv_s1)))
		else $error("input port register not written");
`endif

endmodule
